// ===== src/motor_command_frame_decoder_defines.svh =====
// assertion macros for the motor command frame decoder
`ifndef MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define MCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold at the next clock edge after the antecedent
`define MCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mcfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcfd_pkg;

  localparam int FRAME_BYTES = 19;
  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int SIX_LEN = 19;
  localparam int SHORT_LEN = 9;

  localparam int IN_TDATA_W = 88;
  localparam int OUT_TDATA_W = 136;

  localparam logic [7:0] SOF_0 = 8'h55;
  localparam logic [7:0] SOF_1 = 8'hAA;
  localparam logic [7:0] SOF_2 = 8'h38;
  localparam logic [7:0] LEN_SIX = 8'h0C;
  localparam logic [7:0] LEN_SHORT = 8'h02;
  localparam logic [7:0] ID_SIX = 8'h08;
  localparam logic [7:0] ID_SHOOT = 8'h09;
  localparam logic [7:0] ID_ENC = 8'h08;
  localparam logic [7:0] ID_ADC = 8'h07;
  localparam logic [7:0] CLS_MOTION = 8'h70;
  localparam logic [7:0] CLS_CONFIG = 8'h60;

  localparam logic signed [15:0] WHEEL_LIM = 16'sd4000;
  localparam logic signed [15:0] DRIB_LIM = 16'sd6000;
  localparam logic [13:0] REMOTE_DRIB = 14'd3000;
  localparam logic [15:0] REMOTE_SHOT = 16'd3000;
  localparam logic [15:0] LIFT_STEP = 16'd10;
  localparam logic [10:0] STICK_HI = 11'd1026;
  localparam logic [10:0] STICK_LO = 11'd1022;
  localparam logic [15:0] AUX_SHOT = 16'd1684;
  localparam logic [15:0] ADC_PERIOD_RST = 16'd13;
  localparam logic [15:0] ENC_PERIOD_RST = 16'd1500;

  typedef enum logic [2:0] {
    OC_NONE   = 3'd0,
    OC_REMOTE = 3'd1,
    OC_MOTOR  = 3'd2,
    OC_SHOOT  = 3'd3,
    OC_ENC    = 3'd4,
    OC_ADC    = 3'd5,
    OC_CSUM   = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [12:0] wheel_a;
    logic [12:0] wheel_b;
    logic [12:0] wheel_c;
    logic [13:0] drib_right;
    logic [13:0] drib_left;
    logic [15:0] lift;
    logic [15:0] shot;
    logic [15:0] adc_period;
    logic [15:0] enc_period;
  } setpoint_t;

  typedef struct packed {
    logic [1:0]  remote_switch;
    logic [10:0] stick;
    logic [15:0] aux;
    logic [15:0] kin_a;
    logic [15:0] kin_b;
    logic [15:0] kin_c;
  } tick_t;

  typedef struct packed {
    logic             pending;
    logic [POS_W-1:0] pos;
    logic [7:0]       running_sum;
    logic [7:0]       sum_at_eight;
  } frame_stat_t;

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                 input logic signed [15:0] lim);
    logic signed [15:0] res;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // halve toward zero
  function automatic logic signed [15:0] halve16(input logic signed [15:0] v);
    logic signed [15:0] t;
    t = $signed(v + {15'd0, v[15]});
    return t >>> 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/mcfd_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcfd_eval (
  input  logic [7:0]           frame [mcfd_pkg::FRAME_BYTES],
  input  mcfd_pkg::frame_stat_t fstat,
  input  mcfd_pkg::tick_t      tick,
  input  mcfd_pkg::setpoint_t  sp_cur,
  output mcfd_pkg::setpoint_t  sp_nxt,
  output mcfd_pkg::outcome_t   outcome
);
  import mcfd_pkg::*;

  logic               lead;
  logic               is_six;
  logic               is_shoot;
  logic               is_enc;
  logic               is_adc;
  logic               six_sum_ok;
  logic               short_sum_ok;
  logic signed [15:0] w_a;
  logic signed [15:0] w_b;
  logic signed [15:0] w_c;
  logic signed [15:0] w_dr;
  logic signed [15:0] w_dl;
  logic [15:0]        short_val;

  assign lead = (frame[0] == SOF_0) && (frame[1] == SOF_1) && (frame[2] == SOF_2);
  assign is_six = (frame[3] == LEN_SIX) && (frame[4] == ID_SIX) && (frame[5] == CLS_MOTION);
  assign is_shoot = (frame[4] == ID_SHOOT) && (frame[5] == CLS_MOTION);
  assign is_enc = (frame[4] == ID_ENC) && (frame[5] == CLS_CONFIG) && (frame[6] == 8'h00);
  assign is_adc = (frame[4] == ID_ADC) && (frame[5] == CLS_CONFIG);
  assign six_sum_ok = frame[SIX_LEN-1] == fstat.running_sum;
  assign short_sum_ok = frame[SHORT_LEN-1] == fstat.sum_at_eight;

  assign w_a = $signed({frame[10], frame[11]});
  assign w_b = $signed({frame[8], frame[9]});
  assign w_c = $signed({frame[6], frame[7]});
  assign w_dr = $signed({frame[14], frame[15]});
  assign w_dl = $signed(16'd0 - {frame[12], frame[13]});
  assign short_val = {frame[6], frame[7]};

  always_comb begin
    sp_nxt = sp_cur;
    outcome = OC_NONE;
    priority if (tick.remote_switch == 2'd1) begin
      outcome = OC_REMOTE;
      sp_nxt.wheel_a = 13'(clamp16($signed(tick.kin_a), WHEEL_LIM));
      sp_nxt.wheel_b = 13'(clamp16($signed(tick.kin_b), WHEEL_LIM));
      sp_nxt.wheel_c = 13'(clamp16($signed(tick.kin_c), WHEEL_LIM));
      sp_nxt.drib_right = REMOTE_DRIB;
      sp_nxt.drib_left = REMOTE_DRIB;
      if (tick.stick >= STICK_HI) begin
        sp_nxt.lift = sp_cur.lift + LIFT_STEP;
      end else if (tick.stick <= STICK_LO) begin
        sp_nxt.lift = sp_cur.lift - LIFT_STEP;
      end
      if (tick.aux == AUX_SHOT) begin
        sp_nxt.shot = REMOTE_SHOT;
      end
    end else if (!fstat.pending || (fstat.pos < POS_W'(SHORT_LEN)) || !lead) begin
      outcome = OC_NONE;
    end else if (is_six) begin
      if (fstat.pos < POS_W'(SIX_LEN)) begin
        outcome = OC_NONE;
      end else if (!six_sum_ok) begin
        outcome = OC_CSUM;
      end else begin
        outcome = OC_MOTOR;
        sp_nxt.wheel_a = 13'(clamp16(halve16(w_a), WHEEL_LIM));
        sp_nxt.wheel_b = 13'(clamp16(halve16(w_b), WHEEL_LIM));
        sp_nxt.wheel_c = 13'(clamp16(halve16(w_c), WHEEL_LIM));
        sp_nxt.drib_right = 14'(clamp16(w_dr, DRIB_LIM));
        sp_nxt.drib_left = 14'(clamp16(w_dl, DRIB_LIM));
        sp_nxt.lift = {frame[16], frame[17]};
      end
    end else if ((frame[3] != LEN_SHORT) || !(is_shoot || is_enc || is_adc)) begin
      outcome = OC_NONE;
    end else if (!short_sum_ok) begin
      outcome = OC_CSUM;
    end else if (is_shoot) begin
      outcome = OC_SHOOT;
      sp_nxt.shot = short_val;
    end else if (is_enc) begin
      outcome = OC_ENC;
      sp_nxt.enc_period = short_val;
    end else begin
      outcome = OC_ADC;
      sp_nxt.adc_period = short_val;
    end
  end

endmodule

`default_nettype wire

// ===== src/motor_command_frame_decoder.sv =====
// motor command frame decoder
// input channel (in_*): one transaction per cycle at most. in_tuser = 0 carries a
// host command byte in in_tdata[7:0], with in_tlast marking the last byte of the
// receive window. in_tuser = 1 is an evaluation tick carrying the remote switch,
// stick, aux and kinematics wheel speeds in in_tdata.
// a byte transaction gives no result. every tick gives exactly one result on the
// output channel (out_*): all current setpoints and report periods in out_tdata
// and the outcome code in out_tuser.
// a tick in the input register is evaluated into the setpoint registers and
// raises out_tvalid. throughput: one transaction per cycle unless the output
// stalls, set by the single input register feeding one combinational evaluation.
// a stalled receiver holds the result; bytes keep flowing past it and a
// following tick waits in the input register, after which in_tready drops.
// reset (rst_n low, synchronous) empties both registers, drops any partial
// window and restores setpoints to zero, periods to 13 and 1500 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "motor_command_frame_decoder_defines.svh"

module motor_command_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // frame_byte, remote_switch, stick_channel, aux_channel, kin_rpm_a, kin_rpm_b, kin_rpm_c
  input  logic [mcfd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // wheel_speed_a, wheel_speed_b, wheel_speed_c, dribble_right, dribble_left,
  // lift_speed, shoot_power, adc_interval, enc_interval
  output logic [mcfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // outcome
  output logic [2:0]                       out_tuser
);
  import mcfd_pkg::*;

  logic                  in_vld_r;
  logic [IN_TDATA_W-1:0] in_data_r;
  logic                  in_user_r;
  logic                  in_last_r;
  logic                  out_vld_r;
  outcome_t              outcome_r;
  outcome_t              outcome_nxt;
  setpoint_t             sp_r;
  setpoint_t             sp_nxt;
  logic [7:0]            store_r [FRAME_BYTES];
  logic [POS_W-1:0]      pos_r;
  logic [7:0]            rsum_r;
  logic [7:0]            sum8_r;
  logic                  pending_r;
  logic                  fire;
  logic                  tick_fire;
  logic                  byte_fire;
  logic                  take_byte;
  logic [7:0]            in_byte;
  tick_t                 tick;
  frame_stat_t           fstat;
  logic                  wheel_a_ok;
  logic                  past_eight;

  assign fire = in_vld_r && (!in_user_r || !out_vld_r || out_tready);
  assign tick_fire = fire && in_user_r;
  assign byte_fire = fire && !in_user_r;
  assign take_byte = byte_fire && !pending_r;
  assign in_tready = !in_vld_r || fire;

  assign in_byte = in_data_r[7:0];
  assign tick.remote_switch = in_data_r[9:8];
  assign tick.stick = in_data_r[20:10];
  assign tick.aux = in_data_r[36:21];
  assign tick.kin_a = in_data_r[52:37];
  assign tick.kin_b = in_data_r[68:53];
  assign tick.kin_c = in_data_r[84:69];

  assign fstat.pending = pending_r;
  assign fstat.pos = pos_r;
  assign fstat.running_sum = rsum_r;
  assign fstat.sum_at_eight = sum8_r;

  mcfd_eval u_eval (
    .frame   (store_r),
    .fstat   (fstat),
    .tick    (tick),
    .sp_cur  (sp_r),
    .sp_nxt  (sp_nxt),
    .outcome (outcome_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte && (pos_r < POS_W'(FRAME_BYTES))) begin
      store_r[pos_r[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rsum_r <= '0;
      sum8_r <= '0;
      pending_r <= 1'b0;
    end else if (tick_fire && pending_r) begin
      pos_r <= '0;
      rsum_r <= '0;
      sum8_r <= '0;
      pending_r <= 1'b0;
    end else if (take_byte) begin
      if (pos_r < POS_W'(FRAME_BYTES)) begin
        pos_r <= pos_r + POS_W'(1);
        if (pos_r < POS_W'(SIX_LEN - 1)) begin
          rsum_r <= rsum_r + in_byte;
        end
        if (pos_r < POS_W'(SHORT_LEN - 1)) begin
          sum8_r <= sum8_r + in_byte;
        end
      end
      if (in_last_r) begin
        pending_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      outcome_r <= OC_NONE;
      sp_r <= '{wheel_a: '0, wheel_b: '0, wheel_c: '0, drib_right: '0, drib_left: '0,
                lift: '0, shot: '0, adc_period: ADC_PERIOD_RST,
                enc_period: ENC_PERIOD_RST};
    end else if (tick_fire) begin
      out_vld_r <= 1'b1;
      outcome_r <= outcome_nxt;
      sp_r <= sp_nxt;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser = outcome_r;
  assign out_tdata = {5'd0, sp_r.enc_period, sp_r.adc_period, sp_r.shot, sp_r.lift,
                      sp_r.drib_left, sp_r.drib_right, sp_r.wheel_c, sp_r.wheel_b,
                      sp_r.wheel_a};

  assign wheel_a_ok = ($signed(sp_r.wheel_a) <= 13'sd4000) &&
                      ($signed(sp_r.wheel_a) >= -13'sd4000);
  assign past_eight = byte_fire && (pos_r >= POS_W'(SHORT_LEN - 1));

  `MCFD_ASSERT(a_pos_bound, pos_r <= POS_W'(FRAME_BYTES), "byte position past frame store")
  `MCFD_ASSERT_NEXT(a_tick_drops_frame, tick_fire, !pending_r, "held frame kept after tick")
  `MCFD_ASSERT(a_result_from_tick, $rose(out_tvalid) |-> $past(tick_fire), "result without tick")
  `MCFD_ASSERT(a_wheel_range, wheel_a_ok, "wheel a out of range")
  `MCFD_ASSERT_NEXT(a_sum8_frozen, past_eight, $stable(sum8_r), "short sum moved past byte eight")

endmodule

`default_nettype wire
